FILE: design/swle_pkg.sv
// Shared types and constants for the sliding-window loss estimator.
package swle_pkg;

   localparam int SENDER_W = 8;
   localparam int SEQ_W    = 16;
   localparam int TIME_W   = 32;
   localparam int PCT_W    = 7;
   localparam int SPAN_W   = SEQ_W + 1;
   localparam int REM_W    = SPAN_W + PCT_W;

   localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd30000;
   localparam logic [PCT_W-1:0]  PCT_SCALE    = 7'd100;

   typedef struct packed {
      logic [SEQ_W-1:0]  seq;
      logic [TIME_W-1:0] stamp;
   } ring_entry_type;

   typedef struct packed {
      logic              start;
      logic [SPAN_W-1:0] span;
      logic [SPAN_W-1:0] miss;
   } div_req_type;

endpackage

FILE: design/swle_ptr_table.sv
// Per-sender head pointer and fill count table with valid bits.
module swle_ptr_table #(
   parameter int SW = 3,
   parameter int RW = 8,
   parameter int FW = 9
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [SW-1:0] rd_addr,
   output logic [RW-1:0] rd_head,
   output logic [FW-1:0] rd_fill,
   input  logic          wr_en,
   input  logic [SW-1:0] wr_addr,
   input  logic [RW-1:0] wr_head,
   input  logic [FW-1:0] wr_fill
);
   import swle_pkg::*;

   localparam int DEPTH = 2 ** SW;

   logic [RW+FW-1:0] tbl_mem [DEPTH];
   logic [RW+FW-1:0] rd_data_ff;
   logic             rd_vld_ff;
   logic [DEPTH-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tbl_mem[wr_addr] <= {wr_head, wr_fill};
      end
      rd_data_ff <= tbl_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= vld_ff[rd_addr];
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // never-written sender reads as empty ring
   assign rd_head = rd_vld_ff ? rd_data_ff[RW+FW-1:FW] : '0;
   assign rd_fill = rd_vld_ff ? rd_data_ff[FW-1:0]     : '0;

endmodule

FILE: design/swle_div.sv
// Iterative restoring divider: pct = miss * 100 / span, one quotient bit per cycle.
module swle_div (
   input  logic                      clock,
   input  logic                      reset,
   input  swle_pkg::div_req_type     div_req,
   output logic [swle_pkg::PCT_W-1:0] pct,
   output logic                      done
);
   import swle_pkg::*;

   logic [REM_W-1:0] rem_ff, rem_in;
   logic [SPAN_W-1:0] den_ff, den_in;
   logic [PCT_W-1:0] quo_ff, quo_in;
   logic [2:0]       step_ff, step_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [REM_W-1:0] trial;

   always_comb begin
      trial   = REM_W'(den_ff) << step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = REM_W'(div_req.miss) * REM_W'(PCT_SCALE);
         den_in  = div_req.span;
         quo_in  = '0;
         step_in = 3'(PCT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in          = rem_ff - trial;
            quo_in[step_ff] = 1'b1;
         end
         if (step_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   assign pct  = quo_ff;
   assign done = done_ff;

endmodule

FILE: design/sliding_window_loss_estimator.sv
// Top level: per-sender arrival rings, window walk and loss percentage.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  req     | in        | req_valid/req_stall| req_sender, req_seq, req_arrival_ms
//  rsp     | out       | rsp_valid/rsp_stall| rsp_loss_valid, rsp_loss_pct, rsp_sender_rejected
//  csr     | in        | csr_wr_en          | csr_wr_data (window length, ms)
//
// One request at a time. The walk reads the older ring entries inside the window (up to
// RING_DEPTH - 1) one entry per cycle, and the divider runs only when loss is nonzero. A
// rejected sender skips the walk and goes straight to the response.
// Synchronous reset clears pointers (via valid bits) and control; ring memory is not cleared.
// The response register frees the walk: a new request is taken while a result waits
// under rsp_stall; only the final hand-off waits for the register to drain.
module sliding_window_loss_estimator #(
   parameter int RING_DEPTH  = 256,
   parameter int NUM_SENDERS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [swle_pkg::SENDER_W-1:0] req_sender,
   input  logic [swle_pkg::SEQ_W-1:0]    req_seq,
   input  logic [swle_pkg::TIME_W-1:0]   req_arrival_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_loss_valid,
   output logic [swle_pkg::PCT_W-1:0]    rsp_loss_pct,
   output logic                          rsp_sender_rejected,
   input  logic                          csr_wr_en,
   input  logic [swle_pkg::TIME_W-1:0]   csr_wr_data
);
   import swle_pkg::*;

   localparam int SW         = (NUM_SENDERS > 1) ? $clog2(NUM_SENDERS) : 1;
   localparam int RW         = $clog2(RING_DEPTH);
   localparam int FW         = $clog2(RING_DEPTH + 1);
   localparam int AW         = SW + RW;
   localparam int RING_SLOTS = 2 ** AW;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PTR  = 3'd1;
   localparam logic [2:0] ST_WALK = 3'd2;
   localparam logic [2:0] ST_CALC = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   // control
   logic [2:0]        state_ff, state_in;
   logic [TIME_W-1:0] window_ff, window_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // request and walk payload
   logic [SW-1:0]     snd_ff, snd_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic [TIME_W-1:0] arr_ff, arr_in;
   logic [RW-1:0]     rd_idx_ff, rd_idx_in;
   logic [FW-1:0]     left_ff, left_in;
   logic              pend_ff, pend_in;
   logic [FW-1:0]     seen_ff, seen_in;
   logic [SEQ_W-1:0]  newest_ff, newest_in;
   logic [SEQ_W-1:0]  oldest_ff, oldest_in;
   logic              res_valid_ff, res_valid_in;
   logic [PCT_W-1:0]  res_pct_ff, res_pct_in;
   logic              res_rej_ff, res_rej_in;
   logic              rsp_loss_valid_ff, rsp_loss_valid_in;
   logic [PCT_W-1:0]  rsp_loss_pct_ff, rsp_loss_pct_in;
   logic              rsp_rej_ff, rsp_rej_in;

   // ring memory
   ring_entry_type    ring_mem [RING_SLOTS];
   ring_entry_type    rd_ent_ff;
   logic              ring_we;
   logic [AW-1:0]     ring_wa;
   logic [AW-1:0]     ring_ra;

   // pointer table
   logic [RW-1:0]     tbl_head;
   logic [FW-1:0]     tbl_fill;
   logic [RW-1:0]     new_head;
   logic [FW-1:0]     new_fill;

   // divider
   div_req_type       div_req;
   logic [PCT_W-1:0]  div_pct;
   logic              div_done;

   logic              accept;
   logic              in_range;
   logic [TIME_W-1:0] age;
   logic              stop;
   logic [SPAN_W-1:0] span;
   logic [SPAN_W-1:0] seen_x;
   logic              out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign in_range  = ({1'b0, req_sender} < 9'(NUM_SENDERS));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // ring write: newest arrival at current head; walk reads older slots
   assign ring_we = (state_ff == ST_PTR);
   assign ring_wa = {snd_ff, tbl_head};
   assign ring_ra = {snd_ff, rd_idx_ff};

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_wa] <= '{seq: seq_ff, stamp: arr_ff};
      end
      rd_ent_ff <= ring_mem[ring_ra];
   end

   assign new_head = (tbl_head == RW'(RING_DEPTH - 1)) ? '0 : tbl_head + 1'b1;
   assign new_fill = (tbl_fill == FW'(RING_DEPTH)) ? tbl_fill : tbl_fill + 1'b1;

   swle_ptr_table #(
      .SW(SW),
      .RW(RW),
      .FW(FW)
   ) u_ptr_table (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (req_sender[SW-1:0]),
      .rd_head (tbl_head),
      .rd_fill (tbl_fill),
      .wr_en   (state_ff == ST_PTR),
      .wr_addr (snd_ff),
      .wr_head (new_head),
      .wr_fill (new_fill)
   );

   // wrap-safe age; an entry stamped later than the arrival looks very old
   assign age  = arr_ff - rd_ent_ff.stamp;
   assign stop = pend_ff && (age > window_ff);

   assign span   = SPAN_W'(SEQ_W'(newest_ff - oldest_ff)) + 1'b1;
   assign seen_x = SPAN_W'(seen_ff);

   assign div_req.start = (state_ff == ST_CALC) && (seen_ff >= FW'(2)) && (span > seen_x);
   assign div_req.span  = span;
   assign div_req.miss  = span - seen_x;

   swle_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .pct     (div_pct),
      .done    (div_done)
   );

   always_comb begin
      state_in          = state_ff;
      window_in         = csr_wr_en ? csr_wr_data : window_ff;
      snd_in            = snd_ff;
      seq_in            = seq_ff;
      arr_in            = arr_ff;
      rd_idx_in         = rd_idx_ff;
      left_in           = left_ff;
      pend_in           = 1'b0;
      seen_in           = seen_ff;
      newest_in         = newest_ff;
      oldest_in         = oldest_ff;
      res_valid_in      = res_valid_ff;
      res_pct_in        = res_pct_ff;
      res_rej_in        = res_rej_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_loss_valid_in = rsp_loss_valid_ff;
      rsp_loss_pct_in   = rsp_loss_pct_ff;
      rsp_rej_in        = rsp_rej_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               snd_in       = req_sender[SW-1:0];
               seq_in       = req_seq;
               arr_in       = req_arrival_ms;
               res_valid_in = 1'b0;
               res_pct_in   = '0;
               res_rej_in   = !in_range;
               state_in     = in_range ? ST_PTR : ST_DONE;
            end
         end
         ST_PTR: begin
            // newest entry is the arrival itself: always inside the window
            seen_in   = FW'(1);
            newest_in = seq_ff;
            oldest_in = seq_ff;
            rd_idx_in = (tbl_head == '0) ? RW'(RING_DEPTH - 1) : tbl_head - 1'b1;
            left_in   = new_fill - 1'b1;
            state_in  = ST_WALK;
         end
         ST_WALK: begin
            if (pend_ff && !stop) begin
               seen_in   = seen_ff + 1'b1;
               oldest_in = rd_ent_ff.seq;
            end
            if (left_ff != '0 && !stop) begin
               pend_in   = 1'b1;
               left_in   = left_ff - 1'b1;
               rd_idx_in = (rd_idx_ff == '0) ? RW'(RING_DEPTH - 1) : rd_idx_ff - 1'b1;
            end
            if (stop || (left_ff == '0 && !pend_ff)) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            res_valid_in = (seen_ff >= FW'(2));
            if (div_req.start) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_pct_in = div_pct;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_loss_valid_in = res_valid_ff;
               rsp_loss_pct_in   = res_pct_ff;
               rsp_rej_in        = res_rej_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WINDOW_RESET;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      snd_ff            <= snd_in;
      seq_ff            <= seq_in;
      arr_ff            <= arr_in;
      rd_idx_ff         <= rd_idx_in;
      left_ff           <= left_in;
      seen_ff           <= seen_in;
      newest_ff         <= newest_in;
      oldest_ff         <= oldest_in;
      res_valid_ff      <= res_valid_in;
      res_pct_ff        <= res_pct_in;
      res_rej_ff        <= res_rej_in;
      rsp_loss_valid_ff <= rsp_loss_valid_in;
      rsp_loss_pct_ff   <= rsp_loss_pct_in;
      rsp_rej_ff        <= rsp_rej_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_loss_valid      = rsp_loss_valid_ff;
   assign rsp_loss_pct        = rsp_loss_pct_ff;
   assign rsp_sender_rejected = rsp_rej_ff;

   // divider finishes only while the FSM waits on it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside divide state");

   // loss percentage stays below 100
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_loss_pct_ff < PCT_SCALE)
      else $error("loss percentage out of range");

   // rejected sender carries no estimate
   a_rej_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_rej_ff |-> !rsp_loss_valid_ff && rsp_loss_pct_ff == '0)
      else $error("rejected sender with loss estimate");

   // walk never counts more entries than a ring holds
   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> seen_ff <= FW'(RING_DEPTH))
      else $error("window count exceeds ring depth");

   // an accepted request always leaves idle
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted request left FSM idle");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sliding-window loss estimator.

module tb;
   import swle_pkg::*;

   localparam int RING_DEPTH  = 256;
   localparam int NUM_SENDERS = 8;
   localparam int IDLE_PCT    = 38;
   // receiver hold-off, long enough to back up the request side
   localparam int HOLD_AT     = 200;
   localparam int HOLD_CYCLES = 3000;
   // tail wait after the last result: a full ring walk plus the divider
   localparam int TAIL_CYCLES = RING_DEPTH + 40;

   typedef struct packed {
      logic [SENDER_W-1:0] sender;
      logic [SEQ_W-1:0]    seq;
      logic [TIME_W-1:0]   arrival;
   } packet_type;

   typedef struct packed {
      logic             loss_valid;
      logic [PCT_W-1:0] loss_pct;
      logic             rejected;
   } loss_type;

   // ---------------------------------------------------------------
   // Clock, DUT ports (every input known from time zero)
   // ---------------------------------------------------------------
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [SENDER_W-1:0] req_sender = '0;
   logic [SEQ_W-1:0]    req_seq = '0;
   logic [TIME_W-1:0]   req_arrival_ms = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_loss_valid;
   logic [PCT_W-1:0]    rsp_loss_pct;
   logic                rsp_sender_rejected;
   logic                csr_wr_en = 1'b0;
   logic [TIME_W-1:0]   csr_wr_data = '0;

   always #5 clock = ~clock;

   sliding_window_loss_estimator #(
      .RING_DEPTH  (RING_DEPTH),
      .NUM_SENDERS (NUM_SENDERS)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sender          (req_sender),
      .req_seq             (req_seq),
      .req_arrival_ms      (req_arrival_ms),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_loss_valid      (rsp_loss_valid),
      .rsp_loss_pct        (rsp_loss_pct),
      .rsp_sender_rejected (rsp_sender_rejected),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   // ---------------------------------------------------------------
   // Predictor state: per-sender arrival rings and the window length
   // ---------------------------------------------------------------
   logic [SEQ_W-1:0]  ring_seq   [NUM_SENDERS][RING_DEPTH];
   logic [TIME_W-1:0] ring_stamp [NUM_SENDERS][RING_DEPTH];
   int unsigned       ring_head  [NUM_SENDERS];
   int unsigned       ring_fill  [NUM_SENDERS];
   logic [TIME_W-1:0] window_len = WINDOW_RESET;

   packet_type  pending_packets[$];
   loss_type    expected_loss[$];
   int unsigned mismatches = 0;
   bit          calm = 1'b0;     // set during the no-idle stretch

   // Push the packet into its sender's ring, then walk newest-first while the
   // wrap-safe age stays within the window. Out-of-range senders touch nothing.
   function automatic loss_type estimate_loss(packet_type p);
      loss_type          r;
      int unsigned       s, idx, seen, span, i;
      logic [SEQ_W-1:0]  newest, oldest, diff;
      logic [TIME_W-1:0] age;
      r = '0;
      if (p.sender >= NUM_SENDERS) begin
         r.rejected = 1'b1;
         return r;
      end
      s = p.sender;
      ring_seq[s][ring_head[s]]   = p.seq;
      ring_stamp[s][ring_head[s]] = p.arrival;
      ring_head[s] = (ring_head[s] + 1) % RING_DEPTH;
      if (ring_fill[s] < RING_DEPTH)
         ring_fill[s]++;
      seen   = 0;
      newest = '0;
      oldest = '0;
      for (i = 0; i < ring_fill[s]; i++) begin
         idx = (ring_head[s] + RING_DEPTH - 1 - i) % RING_DEPTH;
         age = p.arrival - ring_stamp[s][idx];
         if (age > window_len)
            break;   // inclusive edge; a later stamp wraps to a huge age
         if (seen == 0)
            newest = ring_seq[s][idx];
         oldest = ring_seq[s][idx];
         seen++;
      end
      if (seen >= 2) begin
         r.loss_valid = 1'b1;
         diff = newest - oldest;
         span = diff + 1;
         // duplicates / reordering can make span <= seen: no loss
         if (span > seen)
            r.loss_pct = PCT_W'(((span - seen) * int'(PCT_SCALE)) / span);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Driver: offers pending requests, holds payload while stalled
   // ---------------------------------------------------------------
   packet_type on_wire = '0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_loss.push_back(estimate_loss(on_wire));
         if (!(req_valid && req_stall)) begin
            if (pending_packets.size() != 0 &&
                (calm || $urandom_range(99) >= IDLE_PCT)) begin
               on_wire        = pending_packets.pop_front();
               req_valid      <= 1'b1;
               req_sender     <= on_wire.sender;
               req_seq        <= on_wire.seq;
               req_arrival_ms <= on_wire.arrival;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: random stall, one long hold-off, in-order compare
   // ---------------------------------------------------------------
   int unsigned rsp_count = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;
   loss_type    oldest_exp;

   task automatic check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (expected_loss.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual valid=%0b pct=%0d rej=%0b",
                        $time, rsp_loss_valid, rsp_loss_pct, rsp_sender_rejected);
               mismatches++;
            end else begin
               oldest_exp = expected_loss.pop_front();
               check_field("loss_valid", oldest_exp.loss_valid, rsp_loss_valid);
               check_field("loss_pct", oldest_exp.loss_pct, rsp_loss_pct);
               check_field("sender_rejected", oldest_exp.rejected, rsp_sender_rejected);
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && rsp_count >= HOLD_AT) begin
            // the request side keeps offering; the block must back up
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   logic [SEQ_W-1:0]  stream_seq [NUM_SENDERS];
   logic [TIME_W-1:0] stream_ms  [NUM_SENDERS];

   function automatic void add_packet(int unsigned sender, int unsigned seq,
                                      logic [TIME_W-1:0] arrival);
      packet_type p;
      p.sender  = SENDER_W'(sender);
      p.seq     = SEQ_W'(seq);
      p.arrival = arrival;
      pending_packets.push_back(p);
   endfunction

   // Mostly well-formed per-sender streams (in-order seq, rising time) with
   // gaps, duplicates and late packets; the rest is noise and bad senders.
   // focus >= 0 steers three quarters of the valid-sender packets to one sender.
   task automatic queue_stream(int count, int unsigned step_max, int focus);
      int unsigned r, k, s;
      logic [SEQ_W-1:0] sq;
      repeat (count) begin
         r = $urandom_range(99);
         if (r < 7) begin
            add_packet($urandom_range(255, NUM_SENDERS), $urandom, $urandom);
         end else begin
            s = (focus >= 0 && $urandom_range(3) != 0) ? focus
                                                       : $urandom_range(NUM_SENDERS - 1);
            if (r < 14) begin
               add_packet(s, $urandom, $urandom);
            end else begin
               stream_ms[s] += $urandom_range(step_max);
               k = $urandom_range(99);
               if (k < 10) begin
                  sq = stream_seq[s] - 1 - SEQ_W'($urandom_range(3));  // repeat / late
               end else begin
                  if (k < 30)
                     stream_seq[s] += SEQ_W'($urandom_range(1, 6));    // lost packets
                  sq = stream_seq[s];
                  stream_seq[s]++;
               end
               add_packet(s, sq, stream_ms[s]);
            end
         end
      end
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_packets.size() != 0 || req_valid || expected_loss.size() != 0);
   endtask

   // Block is idle here: every request has produced its one result.
   task automatic run_phase(logic [TIME_W-1:0] win, int count, int unsigned step_max,
                            int focus, bit quiet);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= win;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      window_len = win;
      @(negedge clock);
      calm = quiet;
      queue_stream(count, step_max, focus);
      wait_drained();
      calm = 1'b0;
   endtask

   initial begin
      for (int s = 0; s < NUM_SENDERS; s++) begin
         ring_head[s]  = 0;
         ring_fill[s]  = 0;
         stream_seq[s] = SEQ_W'($urandom);
         // odd senders start just short of the time wrap
         stream_ms[s]  = (s % 2) ? 32'hFFFF_FFFF - $urandom_range(20000) : $urandom;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, reset window (30000 ms)
      add_packet(0, 0, 0);                          // lone arrival: not valid
      add_packet(0, 1, 100);                        // no loss
      add_packet(0, 5, 200);                        // gap: 50%
      add_packet(0, 5, 300);                        // duplicate
      add_packet(0, 3, 400);                        // reorder, span below count
      add_packet(1, 16'hFFFE, 1000);
      add_packet(1, 16'h0001, 1100);                // sequence wrap
      add_packet(1, 16'h0002, 31100);               // age exactly the window: inside
      add_packet(4, 100, 0);
      add_packet(4, 101, 30001);                    // one past the window: outside
      add_packet(2, 10, 32'hFFFF_FF00);
      add_packet(2, 20, 32'h0000_0100);             // time wrap
      add_packet(2, 21, 32'h0000_0050);             // older stamp later: walk stops
      add_packet(3, 0, 5000);
      add_packet(3, 16'hFFFF, 5001);                // widest span: 99%
      add_packet(7, 16'hFFFF, 32'hFFFF_FFFF);       // top valid sender
      add_packet(7, 0, 32'hFFFF_FFFF);
      add_packet(6, 16'hAAAA, 32'h5555_5555);
      add_packet(6, 16'h5555, 32'hAAAA_AAAA);
      add_packet(NUM_SENDERS, 1, 1);                // first bad sender
      add_packet(255, 16'hFFFF, 32'hFFFF_FFFF);
      add_packet(128, 0, 0);
      wait_drained();

      run_phase(32'd1000, 300, 400, -1, 1'b1);        // short window, no idling
      run_phase(32'd0, 150, 2, -1, 1'b0);             // zero window: same-ms only
      run_phase(32'hFFFF_FFFF, 300, 1000, 5, 1'b0);   // everything inside; ring wraps
      run_phase($urandom, 300, 5000, 3, 1'b0);
      run_phase(WINDOW_RESET, 550, 2000, -1, 1'b0);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_loss.size() != 0) begin
         $display("%0t: missing responses: expected %0d more, actual 0",
                  $time, expected_loss.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule

FILE: sliding_window_loss_estimator.f
design/swle_pkg.sv
design/swle_ptr_table.sv
design/swle_div.sv
design/sliding_window_loss_estimator.sv
verif/tb.sv
